// ===== rtl/tip_pkg.sv =====
`default_nettype none
package tip_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int OFFSET_BITS = 16;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [63:0] VAL_MASK = 64'((65'd1 << VALUE_BITS) - 65'd1);

    // register indexes on the configuration channel
    localparam logic [7:0] REG_RADIX  = 8'd0;
    localparam logic [7:0] REG_SIGNED = 8'd1;

    localparam logic [5:0] RADIX_RESET = 6'd10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;

    // classified character as handed from front to back
    typedef struct packed {
        logic       first;
        logic       blank;
        logic       minus;
        logic       plus;
        logic       zero;
        logic       xch;
        logic       alnum;
        logic [5:0] dval;
    } t_cls;

    typedef struct packed {
        logic idle;
        logic emit;
    } t_back_stat;

endpackage
`default_nettype wire

// ===== rtl/text_to_integer_parser.sv =====
`default_nettype none
// streaming string-to-integer parser, strtol/strtoul style
// input stream: one character a word, tdata[7:0] = ch, tuser = first (start of a new
//   string, clears the parser). leading blanks, a sign and a base prefix are consumed,
//   then digits below the base are accumulated modulo 2^64
// output stream: one word per string that no start flag cuts off, at the first character
//   not consumed (nul too): tdata[63:0] = value, tdata[79:64] = end_offset (consumed, saturating)
// configuration channel: index 0 = radix (0 detects 0x / 0 prefix), index 1 =
//   signed_mode; always ready, write only while no string is in flight
// throughput: one character per cycle while the result register is not blocked; the front
//   classifies and queues characters in a 4-word queue, the back holds a 64x6 multiply-add
//   accumulator that is combinational into its register
// result path: the character that ends the parse passes a queue entry, then the back
//   output register, which holds the result word until it is taken
// stall: while the result register waits on m_axis_tready the back stops and the
//   queue fills; s_axis_tready drops only when the queue is full
// reset: parser idle (characters ignored until a start flag), queue empty, output
//   empty, radix 10, signed_mode 1
module text_to_integer_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  wire logic        i_s_axis_tuser,   // [0] first
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,   // [63:0] value, [79:64] end_offset
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic                 r_signed_mode;
    logic [5:0]           r_radix;
    tip_pkg::t_cls        w_head;
    logic                 w_head_valid;
    logic                 w_pop;
    logic [63:0]          w_value;
    logic [15:0]          w_offset;
    tip_pkg::t_back_stat  w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= tip_pkg::RADIX_RESET;
            r_signed_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tip_pkg::REG_RADIX) begin
                r_radix <= i_cfg_data[5:0];
            end else if (i_cfg_index == tip_pkg::REG_SIGNED) begin
                r_signed_mode <= i_cfg_data[0];
            end
        end
    end

    tip_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_ch         (i_s_axis_tdata),
        .i_first      (i_s_axis_tuser),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    tip_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_head_valid  (w_head_valid),
        .o_pop         (w_pop),
        .i_radix       (r_radix),
        .i_signed_mode (r_signed_mode),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_value       (w_value),
        .o_end_offset  (w_offset),
        .o_stat        (w_stat)
    );

    assign o_m_axis_tdata = {w_offset, w_value};

    // the back never takes a word while the result register is blocked
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("back popped with result register blocked");

    // an idle parser without a start flag produces nothing
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.idle && w_head_valid && !w_head.first) |-> !w_stat.emit)
        else $error("result emitted from idle parser");

    // a new result word only follows a word taken by the back
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_pop && w_stat.emit))
        else $error("result appeared without a consumed word");

endmodule
`default_nettype wire

// ===== rtl/tip_front.sv =====
`default_nettype none
module tip_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_ch,
    input  wire logic          i_first,
    output tip_pkg::t_cls      o_head,
    output logic               o_head_valid,
    input  wire logic          i_pop
);

    tip_pkg::t_cls                r_mem [tip_pkg::QDEPTH];
    logic [tip_pkg::QAW-1:0]      r_wr_ptr;
    logic [tip_pkg::QAW-1:0]      r_rd_ptr;
    logic [tip_pkg::QAW:0]        r_count;
    tip_pkg::t_cls                w_cls;
    logic                         w_push;
    logic                         w_pop;

    always_comb begin
        w_cls       = '0;
        w_cls.first = i_first;
        w_cls.blank = (i_ch == tip_pkg::CH_SPACE) || (i_ch == tip_pkg::CH_TAB);
        w_cls.minus = (i_ch == tip_pkg::CH_MINUS);
        w_cls.plus  = (i_ch == tip_pkg::CH_PLUS);
        w_cls.zero  = (i_ch == tip_pkg::CH_0);
        w_cls.xch   = (i_ch == tip_pkg::CH_LX) || (i_ch == tip_pkg::CH_UX);
        if (i_ch >= tip_pkg::CH_0 && i_ch <= tip_pkg::CH_9) begin
            w_cls.alnum = 1'b1;
            w_cls.dval  = 6'(i_ch - tip_pkg::CH_0);
        end else if (i_ch >= tip_pkg::CH_LA && i_ch <= tip_pkg::CH_LZ) begin
            w_cls.alnum = 1'b1;
            w_cls.dval  = 6'(i_ch - tip_pkg::CH_LA + 8'd10);
        end else if (i_ch >= tip_pkg::CH_UA && i_ch <= tip_pkg::CH_UZ) begin
            w_cls.alnum = 1'b1;
            w_cls.dval  = 6'(i_ch - tip_pkg::CH_UA + 8'd10);
        end
    end

    assign o_ready      = (r_count != (tip_pkg::QAW+1)'(tip_pkg::QDEPTH));
    assign w_push       = i_valid && o_ready;
    assign o_head_valid = (r_count != '0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cls;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tip_back.sv =====
`default_nettype none
module tip_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tip_pkg::t_cls i_head,
    input  wire logic          i_head_valid,
    output logic               o_pop,
    input  wire logic [5:0]    i_radix,
    input  wire logic          i_signed_mode,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [63:0]        o_value,
    output logic [15:0]        o_end_offset,
    output tip_pkg::t_back_stat o_stat
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS
    } t_ph;

    localparam int VB = tip_pkg::VALUE_BITS;
    localparam int OB = tip_pkg::OFFSET_BITS;

    t_ph                 r_ph,   n_ph;
    logic [VB-1:0]       r_acc,  n_acc;
    logic [OB-1:0]       r_cons, n_cons;
    logic                r_neg,  n_neg;
    logic [5:0]          r_ar,   n_ar;
    logic                r_valid;
    logic [63:0]         r_value;
    logic [15:0]         r_offset;

    t_ph                 w_ph;
    logic [VB-1:0]       w_acc;
    logic [OB-1:0]       w_cons;
    logic [1:0]          w_inc;
    logic [OB:0]         w_sum;
    logic                w_emit;
    logic                w_prefix;
    logic                w_digit;
    logic                w_use_mac;
    logic [5:0]          w_rad;
    logic [VB-1:0]       w_mac;
    logic [VB-1:0]       w_neg_val;
    logic [63:0]         w_out_val;

    assign o_pop = i_head_valid && (!r_valid || i_ready);

    // accumulator feedback: one multiply-add on the held radix
    assign w_mac = VB'(r_acc * VB'(r_ar)) + VB'(i_head.dval);

    always_comb begin
        w_ph   = r_ph;
        w_acc  = r_acc;
        w_cons = r_cons;
        n_neg  = r_neg;
        n_ar   = r_ar;
        if (i_head.first) begin
            w_ph   = PH_LEAD;
            w_acc  = '0;
            w_cons = '0;
            n_neg  = 1'b0;
            n_ar   = '0;
        end
        n_ph      = w_ph;
        n_acc     = w_acc;
        w_inc     = 2'd0;
        w_emit    = 1'b0;
        w_prefix  = 1'b0;
        w_digit   = 1'b0;
        w_use_mac = 1'b0;
        w_rad     = n_ar;

        unique case (w_ph)
            PH_IDLE: begin
            end
            PH_LEAD: begin
                if (i_head.blank) begin
                    w_inc = 2'd1;
                end else if (i_signed_mode && i_head.minus) begin
                    n_neg = 1'b1;
                    w_inc = 2'd1;
                    n_ph  = PH_PREFIX;
                end else if (i_head.plus) begin
                    w_inc = 2'd1;
                    n_ph  = PH_PREFIX;
                end else begin
                    w_prefix = 1'b1;
                end
            end
            PH_PREFIX: begin
                w_prefix = 1'b1;
            end
            PH_ZERO: begin
                if (i_head.xch) begin
                    w_inc = 2'd2;
                    n_ar  = 6'd16;
                    n_ph  = PH_DIGITS;
                end else begin
                    // the leading zero counts now, then this char is a digit try
                    w_inc   = 2'd1;
                    n_ar    = (r_ar == 6'd0) ? 6'd8 : 6'd16;
                    w_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                w_digit   = 1'b1;
                w_use_mac = 1'b1;
            end
            default: begin
            end
        endcase

        if (w_prefix) begin
            if (i_head.zero && (i_radix == 6'd0 || i_radix == 6'd16)) begin
                n_ar = i_radix;
                n_ph = PH_ZERO;
            end else begin
                n_ar    = (i_radix == 6'd0) ? 6'd10 : i_radix;
                w_digit = 1'b1;
            end
        end

        w_rad = n_ar;
        if (w_digit) begin
            if (i_head.alnum && (i_head.dval < w_rad)) begin
                n_acc = w_use_mac ? w_mac : VB'(i_head.dval);
                w_inc = w_inc + 2'd1;
                n_ph  = PH_DIGITS;
            end else begin
                w_emit = 1'b1;
                n_ph   = PH_IDLE;
            end
        end

        w_sum  = {1'b0, w_cons} + (OB+1)'(w_inc);
        n_cons = w_sum[OB] ? '1 : w_sum[OB-1:0];

        w_neg_val = r_neg ? (VB'(0) - w_acc) : w_acc;
        w_out_val = 64'(w_neg_val);
        if (i_signed_mode && w_neg_val[VB-1]) begin
            w_out_val = w_out_val | ~tip_pkg::VAL_MASK;
        end
        if (i_head.first) begin
            w_out_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= PH_IDLE;
            r_acc   <= '0;
            r_cons  <= '0;
            r_neg   <= 1'b0;
            r_ar    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_ph   <= n_ph;
                r_acc  <= n_acc;
                r_cons <= n_cons;
                r_neg  <= n_neg;
                r_ar   <= n_ar;
            end
            if (o_pop && w_emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_value  <= w_out_val;
            r_offset <= 16'(n_cons);
        end
    end

    assign o_valid       = r_valid;
    assign o_value       = r_value;
    assign o_end_offset  = r_offset;
    assign o_stat.idle   = (r_ph == PH_IDLE);
    assign o_stat.emit   = i_head_valid && w_emit;

endmodule
`default_nettype wire

// ===== tb/tip_stream_checker.sv =====
module tip_stream_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_valid,
    input  wire logic        i_s_ready,
    input  wire logic [7:0]  i_s_data,    // [7:0] ch
    input  wire logic        i_s_user,    // [0] first
    input  wire logic        i_m_valid,
    input  wire logic        i_m_ready,
    input  wire logic [79:0] i_m_data,    // [63:0] value, [79:64] end_offset
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLANKS,
        ST_SIGNED,
        ST_ZERO,
        ST_DIGITS
    } t_parse_state;

    // packed high to low, so offset lands in [79:64] as on the output word
    typedef struct packed {
        logic [15:0] offset;
        logic [63:0] value;
    } t_parsed;

    localparam int unsigned OFS_MAX = (32'd1 << tip_pkg::OFFSET_BITS) - 32'd1;

    logic [5:0]   cfg_radix;
    logic         cfg_signed;
    t_parse_state st;
    logic [63:0]  acc;
    int unsigned  n_used;
    logic         negative;
    logic [5:0]   base;
    logic         emitted;
    t_parsed      emitted_val;
    t_parsed      parsed_q[$];
    int           fails = 0;
    int           checked = 0;

    task automatic log_mismatch(input string msg);
        if (fails < 40)
            $display("%0t ns mismatch: %s", $time, msg);
        fails++;
    endtask

    function automatic int digit_of(input logic [7:0] c);
        if (c >= tip_pkg::CH_0 && c <= tip_pkg::CH_9)
            return int'(c - tip_pkg::CH_0);
        if (c >= tip_pkg::CH_LA && c <= tip_pkg::CH_LZ)
            return int'(c - tip_pkg::CH_LA) + 10;
        if (c >= tip_pkg::CH_UA && c <= tip_pkg::CH_UZ)
            return int'(c - tip_pkg::CH_UA) + 10;
        return -1;
    endfunction

    task automatic count_up(input int unsigned n);
        n_used = (n > OFS_MAX - n_used) ? OFS_MAX : n_used + n;
    endtask

    task automatic close_parse();
        logic [63:0] v;
        v = acc & tip_pkg::VAL_MASK;
        if (negative)
            v = (64'd0 - v) & tip_pkg::VAL_MASK;
        if (cfg_signed && v[tip_pkg::VALUE_BITS-1])
            v = v | ~tip_pkg::VAL_MASK;
        emitted = 1'b1;
        emitted_val.value = v;
        emitted_val.offset = n_used[15:0];
        st = ST_IDLE;
    endtask

    task automatic take_digit(input logic [7:0] c);
        int d;
        d = digit_of(c);
        if (d < 0 || d >= int'(base)) begin
            close_parse();
        end else begin
            acc = (acc * 64'(base) + 64'(d)) & tip_pkg::VAL_MASK;
            count_up(1);
            st = ST_DIGITS;
        end
    endtask

    // radix is taken here, once blanks and sign are behind us
    task automatic at_prefix(input logic [7:0] c);
        if (c == tip_pkg::CH_0 && (cfg_radix == 6'd0 || cfg_radix == 6'd16)) begin
            base = cfg_radix;
            st = ST_ZERO;
        end else begin
            base = (cfg_radix == 6'd0) ? 6'd10 : cfg_radix;
            st = ST_DIGITS;
            take_digit(c);
        end
    endtask

    task automatic parse_char(input logic [7:0] c, input logic start);
        emitted = 1'b0;
        if (start) begin
            st = ST_BLANKS;
            acc = '0;
            n_used = 0;
            negative = 1'b0;
            base = '0;
        end
        case (st)
            ST_BLANKS: begin
                if (c == tip_pkg::CH_SPACE || c == tip_pkg::CH_TAB) begin
                    count_up(1);
                end else if (cfg_signed && c == tip_pkg::CH_MINUS) begin
                    negative = 1'b1;
                    count_up(1);
                    st = ST_SIGNED;
                end else if (c == tip_pkg::CH_PLUS) begin
                    count_up(1);
                    st = ST_SIGNED;
                end else begin
                    at_prefix(c);
                end
            end
            ST_SIGNED: at_prefix(c);
            ST_ZERO: begin
                if (c == tip_pkg::CH_LX || c == tip_pkg::CH_UX) begin
                    count_up(2);
                    base = 6'd16;
                    st = ST_DIGITS;
                end else begin
                    // the leading zero counts; base 0 turns octal, base 16 stays hex
                    count_up(1);
                    base = (base == 6'd0) ? 6'd8 : 6'd16;
                    st = ST_DIGITS;
                    take_digit(c);
                end
            end
            ST_DIGITS: take_digit(c);
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_parsed got;
        t_parsed want;
        if (!i_rst_n) begin
            cfg_radix = tip_pkg::RADIX_RESET;
            cfg_signed = 1'b1;
            st = ST_IDLE;
            acc = '0;
            n_used = 0;
            negative = 1'b0;
            base = '0;
            parsed_q.delete();
        end else begin
            // a word leaves only after its character has passed the queue and result register, so check first
            if (i_m_valid && i_m_ready) begin
                got = i_m_data;
                if (parsed_q.size() == 0) begin
                    log_mismatch($sformatf("result value %h offset %0d with nothing expected",
                                           got.value, got.offset));
                end else begin
                    want = parsed_q.pop_front();
                    if (got.value !== want.value)
                        log_mismatch($sformatf("value %h, expected %h", got.value, want.value));
                    if (got.offset !== want.offset)
                        log_mismatch($sformatf("end_offset %0d, expected %0d",
                                               got.offset, want.offset));
                    checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == tip_pkg::REG_RADIX)
                    cfg_radix = i_cfg_data[5:0];
                else if (i_cfg_index == tip_pkg::REG_SIGNED)
                    cfg_signed = i_cfg_data[0];
            end
            if (i_s_valid && i_s_ready) begin
                parse_char(i_s_data, i_s_user);
                if (emitted)
                    parsed_q.push_back(emitted_val);
            end
        end
        o_fail_count <= fails;
        o_pending <= parsed_q.size();
        o_checked <= checked;
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = '0;
    logic        s_user = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [79:0] m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int checked;

    int         tx_gap_pct = 0;
    int         rx_stall_pct = 0;
    int         chars_sent = 0;
    int         setup_count = 0;
    int         quiet_cycles = 0;
    logic [5:0] radix_now = tip_pkg::RADIX_RESET;
    bit         start_next = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_to_integer_parser DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    tip_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_s_user     (s_user),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, pending);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            @(posedge clk);
            if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic push_char(input logic [7:0] c, input logic start);
        if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data <= c;
        s_user <= start;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
    endtask

    task automatic push_str_char(input logic [7:0] c);
        push_char(c, start_next);
        start_next = 1'b0;
        chars_sent++;
    endtask

    task automatic push_text(input string s);
        start_next = 1'b1;
        for (int i = 0; i < s.len(); i++)
            push_str_char(s[i]);
    endtask

    function automatic logic [7:0] rand_digit(input int b);
        int lim;
        int d;
        lim = (b > 36) ? 36 : b;
        d = $urandom_range(0, lim - 1);
        if (d < 10)
            return tip_pkg::CH_0 + 8'(d);
        return ($urandom_range(0, 1) ? tip_pkg::CH_LA : tip_pkg::CH_UA) + 8'(d - 10);
    endfunction

    task automatic set_config(input logic [5:0] r, input logic sg);
        cfg_valid <= 1'b1;
        cfg_index <= tip_pkg::REG_RADIX;
        cfg_data <= {2'b00, r};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= tip_pkg::REG_SIGNED;
        cfg_data <= {7'd0, sg};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        radix_now = r;
        setup_count++;
    endtask

    // a nul closes any parse still open, then wait for every result and the pipe to empty
    task automatic drain();
        push_char(8'h00, 1'b0);
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic send_random_string();
        int kind;
        int n;
        int b;
        int sign_pick;
        int pre_pick;
        int end_pick;
        kind = $urandom_range(0, 9);
        start_next = 1'b1;
        if (kind == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) push_str_char(8'($urandom_range(0, 255)));
        end else begin
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
                push_str_char($urandom_range(0, 1) ? tip_pkg::CH_SPACE : tip_pkg::CH_TAB);
            sign_pick = $urandom_range(0, 3);
            if (sign_pick == 0)
                push_str_char(tip_pkg::CH_PLUS);
            else if (sign_pick == 1)
                push_str_char(tip_pkg::CH_MINUS);
            b = (radix_now == 6'd0) ? 10 : int'(radix_now);
            pre_pick = $urandom_range(0, 3);
            if (pre_pick == 0) begin
                push_str_char(tip_pkg::CH_0);
                push_str_char($urandom_range(0, 1) ? tip_pkg::CH_LX : tip_pkg::CH_UX);
                if (radix_now == 6'd0 || radix_now == 6'd16)
                    b = 16;
            end else if (pre_pick == 1) begin
                push_str_char(tip_pkg::CH_0);
                if (radix_now == 6'd0)
                    b = 8;
            end
            // long runs can push the value past 64 bits in the larger bases
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 26) : $urandom_range(0, 8);
            repeat (n) push_str_char(rand_digit(b));
            end_pick = $urandom_range(0, 7);
            if (end_pick < 4)
                push_str_char(8'h00);
            else if (end_pick < 7)
                push_str_char(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic random_phase(input logic [5:0] r, input logic sg, input int quota,
                                input bit calm);
        int stop_at;
        drain();
        set_config(r, sg);
        tx_gap_pct = calm ? 0 : $urandom_range(0, 35);
        rx_stall_pct = calm ? 0 : $urandom_range(0, 35);
        stop_at = chars_sent + quota;
        while (chars_sent < stop_at)
            send_random_string();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: radix 10, signed
        push_char("7", 1'b0);           // parser idle, ignored
        push_char(8'hFF, 1'b0);
        push_text("\t-9");
        push_str_char(8'hFF);
        push_text("12");                // dropped by the next start flag
        push_text("+ ");                // sign with no digits gives zero
        drain();
        set_config(6'd0, 1'b1);
        push_text("0xg");               // 0x with no hex digit after it
        push_text("017");
        push_str_char(8'h00);
        drain();
        set_config(6'd16, 1'b0);
        push_text("-1");                // minus not taken when unsigned
        push_text("0XfF");
        push_str_char(8'h00);
        drain();
        set_config(6'd1, 1'b0);
        push_text("01");
        drain();
        set_config(6'd63, 1'b1);
        push_text("zZ9");
        push_str_char(8'h00);

        random_phase(tip_pkg::RADIX_RESET, 1'b1, PHASE_ITEMS, 1'b0);
        random_phase(6'd0, 1'b1, PHASE_ITEMS, 1'b0);
        random_phase(6'd16, 1'b0, PHASE_ITEMS, 1'b0);
        random_phase(6'd2, 1'b1, PHASE_ITEMS, 1'b0);
        random_phase(6'd36, 1'b0, PHASE_ITEMS, 1'b0);
        random_phase(6'd8, 1'b1, PHASE_ITEMS, 1'b0);
        random_phase(6'd1, 1'b0, PHASE_ITEMS, 1'b0);
        random_phase(6'd0, 1'b0, PHASE_ITEMS, 1'b0);
        random_phase(6'd10, 1'b0, PHASE_ITEMS, 1'b0);
        random_phase(6'd35, 1'b1, PHASE_ITEMS, 1'b0);
        random_phase(6'($urandom_range(0, 36)), 1'($urandom_range(0, 1)), 150, 1'b1);
        drain();

        $display("%0d characters streamed under %0d radix/sign settings, %0d results checked",
                 chars_sent, setup_count, checked);
        $display("covered blanks, signs, 0x and octal prefixes, radix 0 to 63, wrap-around, "
                 , "restarts and stalls on both sides");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
